@@ rtl/sfod_pkg.sv @@
`timescale 1ns / 1ps

package sfod_pkg;

    // Fixed field widths
    localparam int FRAME_LEN_W = 11;
    localparam int FLUX_W      = 48;
    localparam int IDX_W       = 32;
    localparam int FRAC_W      = 12;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd1;

    // Register reset values
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 11'd1024;
    localparam logic [FLUX_W-1:0]      THRESHOLD_RST = 48'd1468006;

    localparam logic [FLUX_W-1:0] FLUX_MAX = {FLUX_W{1'b1}};

    typedef logic [FLUX_W-1:0] t_flux;

endpackage

@@ rtl/spectral_flux_onset_detector.sv @@
`timescale 1ns / 1ps

// Spectral flux onset detector.
// Input channel (i_in_valid / o_in_ready / i_magnitude): one UQ12.12 bin per
// transaction, frames of frame_len bins back to back. Output channel
// (o_out_valid / i_out_ready / o_frame_index, o_flux_value, o_onset): one
// transaction per finished frame, taken on the last bin of the frame.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// index 0 = frame_len, index 1 = onset_threshold (UQ36.12). Write only while
// the block is idle; o_cfg_ready is always high.
// Steps: a lower-half bin (after the first frame) passes through READ, DIV,
// ACC and FIN, the radix-2 restoring divider in DIV producing one quotient
// bit per cycle. A lower-half bin of the first frame passes through ACC and
// FIN only, an upper-half bin through FIN only. The last bin of a frame is
// always an upper-half bin; in FIN its result loads the register behind o_out_valid.
// The result sits in an output register, so the next bins are accepted while
// it waits. If the receiver stalls and a second frame ends, the block holds
// in its final step (o_in_ready low) until the register frees up.
// Reset (synchronous, active low) clears the position, sums and frame counter
// and reloads the config defaults; the previous-bin memory is not cleared.
module spectral_flux_onset_detector #(
    parameter int MAX_BINS  = 1024,
    parameter int MAG_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // bin input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [MAG_WIDTH-1:0]                i_magnitude,
    // frame result
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sfod_pkg::IDX_W-1:0]          o_frame_index,
    output logic [sfod_pkg::FLUX_W-1:0]         o_flux_value,
    output logic                                o_onset,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfod_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sfod_pkg::FLUX_W-1:0]         i_cfg_data
);
    import sfod_pkg::*;

    localparam int HALF_BINS = MAX_BINS / 2;
    localparam int ADDR_W    = $clog2(HALF_BINS);
    localparam int LEN_W     = $clog2(MAX_BINS + 1);
    localparam int CMP_W     = (LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W;
    localparam int NUM_W     = MAG_WIDTH + FRAC_W;        // dividend / quotient
    localparam int CNT_W     = $clog2(NUM_W + 1);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(1) << FRAC_W;

    // Config registers
    logic [FRAME_LEN_W-1:0] r_frame_len;
    t_flux                  r_threshold;

    // Control / frame state
    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_pos;
    logic             r_first;
    logic             r_lower;
    t_flux            r_flux_sum;
    t_flux            r_last_flux;
    logic [IDX_W-1:0] r_frame_cnt;

    // Datapath
    logic [MAG_WIDTH-1:0] r_mag;
    logic [MAG_WIDTH-1:0] r_prev;
    logic [MAG_WIDTH-1:0] r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_cnt;

    // Previous-frame bins, lower half only
    logic [MAG_WIDTH-1:0] mem_prev [HALF_BINS];

    // Output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    t_flux            r_out_flux;
    logic             r_out_onset;

    // Effective frame length, clamped to [2, MAX_BINS]
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_clamp;
    logic [LEN_W-1:0] eff_len;
    logic             pos_lower;
    logic             frame_end;
    logic [ADDR_W-1:0] addr;

    always_comb begin
        len_ext = CMP_W'(r_frame_len);
        if (len_ext < CMP_W'(2)) begin
            len_clamp = CMP_W'(2);
        end else if (len_ext > CMP_W'(MAX_BINS)) begin
            len_clamp = CMP_W'(MAX_BINS);
        end else begin
            len_clamp = len_ext;
        end
        eff_len   = LEN_W'(len_clamp);
        pos_lower = r_pos < (eff_len >> 1);
        frame_end = ({1'b0, r_pos} + (LEN_W + 1)'(1)) >= {1'b0, eff_len};
        addr      = r_pos[ADDR_W-1:0];
    end

    // Divider step: shift next dividend bit into the remainder, subtract if it fits
    logic [MAG_WIDTH-1:0] divisor;
    logic [MAG_WIDTH:0]   rem_sh;
    logic                 q_bit;
    logic [MAG_WIDTH:0]   rem_sub;

    always_comb begin
        divisor = (r_prev == '0) ? MAG_WIDTH'(1) : r_prev;
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        q_bit   = rem_sh >= {1'b0, divisor};
        rem_sub = rem_sh - {1'b0, divisor};
    end

    // Contribution and saturating accumulate
    logic [NUM_W-1:0]  contrib;
    logic [FLUX_W:0]   flux_add;
    t_flux             flux_next;

    always_comb begin
        contrib   = (r_quo > ONE_Q) ? (r_quo - ONE_Q) : '0;
        flux_add  = {1'b0, r_flux_sum} + (FLUX_W + 1)'(contrib);
        flux_next = flux_add[FLUX_W] ? FLUX_MAX : flux_add[FLUX_W-1:0];
    end

    logic in_fire;
    logic out_fire;
    logic out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (pos_lower && !r_first) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = pos_lower ? ST_ACC : ST_FIN;
                    end
                end
            end
            ST_READ: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = ST_FIN;
            ST_FIN: begin
                if (!frame_end || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_first     <= 1'b1;
            r_flux_sum  <= '0;
            r_last_flux <= '0;
            r_frame_cnt <= '0;
            r_out_valid <= 1'b0;
            r_frame_len <= FRAME_LEN_RST;
            r_threshold <= THRESHOLD_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FRAME_LEN: r_frame_len <= i_cfg_data[FRAME_LEN_W-1:0];
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end

            // new result loads the output register; otherwise a taken one empties it
            if (r_state == ST_FIN && frame_end && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_ACC && !r_first) begin
                r_flux_sum <= flux_next;
            end

            if (r_state == ST_FIN) begin
                if (!frame_end) begin
                    r_pos <= r_pos + LEN_W'(1);
                end else if (out_free) begin
                    r_frame_cnt <= r_frame_cnt + IDX_W'(1);
                    r_flux_sum  <= '0;
                    r_pos       <= '0;
                    r_first     <= 1'b0;
                    if (!r_first) begin
                        r_last_flux <= r_flux_sum;
                    end
                end
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mag   <= i_magnitude;
            r_lower <= pos_lower;
        end
        unique case (r_state)
            ST_READ: begin
                r_prev <= mem_prev[addr];
                r_rem  <= '0;
                r_quo  <= {r_mag, FRAC_W'(0)};
                r_cnt  <= '0;
            end
            ST_DIV: begin
                r_rem <= q_bit ? rem_sub[MAG_WIDTH-1:0] : rem_sh[MAG_WIDTH-1:0];
                r_quo <= {r_quo[NUM_W-2:0], q_bit};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_ACC: begin
                if (r_lower) begin
                    mem_prev[addr] <= r_mag;
                end
            end
            ST_FIN: begin
                if (frame_end && out_free) begin
                    r_out_index <= r_frame_cnt;
                    r_out_flux  <= r_first ? '0 : r_flux_sum;
                    r_out_onset <= !r_first && (r_flux_sum >= r_threshold)
                                   && (r_last_flux < r_threshold);
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out_index;
    assign o_flux_value  = r_out_flux;
    assign o_onset       = r_out_onset;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input accepted while busy");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside final step");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < divisor))
        else $error("divider remainder out of range");

    a_onset_over_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_onset) |-> (o_flux_value >= r_threshold))
        else $error("onset flagged below threshold");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_flux_value))
        else $error("pending result overwritten");
`endif

endmodule
